### sv/sle_pkg.sv
// sle_pkg: shared constants, opcodes and status codes for the shifting list engine
// no dependencies
`timescale 1ns / 1ps
package sle_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int ITEM_WIDTH_DEF = 32;
  localparam int POS_W = 4;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_INSERT     = 3'd6,
    OP_READ       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_UP    = 2'd2,
    CMD_DOWN  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // per cell control: what to do, and over which ranks (from upto)
  typedef struct packed {
    cmd_t cmd;
    logic [7:0] from;
    logic [7:0] upto;
  } cell_ctl_t;
endpackage

### sv/sle_cell.sv
// sle_cell: one storage cell of the list row
// depends on sle_pkg
`timescale 1ns / 1ps
module sle_cell #(
  parameter int ITEM_WIDTH = sle_pkg::ITEM_WIDTH_DEF,
  parameter int RANK = 0
) (
  input  logic                   clk,
  input  sle_pkg::cell_ctl_t     ctl,
  input  logic [ITEM_WIDTH-1:0]  load_value,
  input  logic [ITEM_WIDTH-1:0]  left_value,
  input  logic [ITEM_WIDTH-1:0]  right_value,
  output logic [ITEM_WIDTH-1:0]  value
);
  import sle_pkg::*;
  logic act;
  assign act = (RANK >= int'(ctl.from)) && (RANK <= int'(ctl.upto));

  always_ff @(posedge clk) begin
    if (act) begin
      case (ctl.cmd)
        CMD_LOAD: value <= load_value;
        CMD_UP:   value <= (RANK == int'(ctl.from)) ? load_value : left_value;
        CMD_DOWN: value <= right_value;
        default:  value <= value;
      endcase
    end
  end
endmodule

### sv/shifting_list_engine.sv
// shifting_list_engine: ordered list held in a row of shifting cells
// push, pop, insert, read go from idle straight to done, which registers out_valid
// find and remove first walk the row, one cell a cycle, until the row ends;
// a find stops early at its first match
// one word at a time: the next word is taken in the cycle its result leaves,
// or later while the receiver stalls the result
// reset clears occupancy and the controller; cell contents stay undefined
`timescale 1ns / 1ps
module shifting_list_engine #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = sle_pkg::ITEM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                opcode,
  input  logic [ITEM_WIDTH-1:0]     item_value,
  input  logic [sle_pkg::POS_W-1:0] position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sle_pkg::DATA_W-1:0] data_out,
  output logic                      found,
  output logic [sle_pkg::POS_W-1:0] found_index,
  output logic [1:0]                status,
  output logic [sle_pkg::CNT_W-1:0] entry_count
);
  import sle_pkg::*;
  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  state_t state, state_next;

  // held request
  op_t                   op;
  logic [ITEM_WIDTH-1:0] val;
  logic [POS_W-1:0]      pos;

  logic [OW-1:0] occupancy;
  logic [OW-1:0] scan;   // read pointer of the walk
  logic [OW-1:0] kept;   // write pointer of the compaction

  logic [ITEM_WIDTH-1:0] cells [DEPTH];
  cell_ctl_t ctl;
  logic [ITEM_WIDTH-1:0] load_value;

  logic accept;
  assign accept = in_valid && in_ready;
  // a waiting result that leaves in this cycle no longer blocks the next word
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // row of cells: each takes a word from its left or right neighbour, or the load value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sle_cell #(.ITEM_WIDTH(ITEM_WIDTH), .RANK(g)) u_cell (
      .clk(clk),
      .ctl(ctl),
      .load_value(load_value),
      .left_value(cells[(g == 0) ? 0 : g - 1]),
      .right_value(cells[(g == DEPTH - 1) ? g : g + 1]),
      .value(cells[g])
    );
  end

  logic pos_ok, full;
  assign pos_ok = OW'(pos) < occupancy;
  assign full = occupancy >= OW'(DEPTH);

  logic [ITEM_WIDTH-1:0] scan_word;
  assign scan_word = cells[scan[IW-1:0]];

  logic scan_end;
  assign scan_end = scan >= occupancy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        state_next = ((op_t'(opcode) == OP_FIND) || (op_t'(opcode) == OP_REMOVE))
                     ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (scan_end || ((op == OP_FIND) && (scan_word == val))) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_t'(opcode);
      val <= item_value;
      pos <= position;
    end
  end

  // cell commands: single edits in the done cycle, compaction moves during the walk
  always_comb begin
    ctl.cmd = CMD_HOLD;
    ctl.from = '0;
    ctl.upto = '0;
    load_value = val;
    if (state == S_DONE) begin
      case (op)
        OP_PUSH_BACK: if (!full) begin
          ctl.cmd = CMD_LOAD;
          ctl.from = 8'(occupancy);
          ctl.upto = 8'(occupancy);
        end
        OP_PUSH_FRONT: if (!full) begin
          ctl.cmd = CMD_UP;
          ctl.upto = 8'(occupancy);
        end
        OP_POP_FRONT: if (occupancy != '0) begin
          ctl.cmd = CMD_DOWN;
          ctl.upto = 8'(DEPTH - 1);
        end
        OP_INSERT: if (pos_ok && !full) begin
          ctl.cmd = CMD_UP;
          ctl.from = 8'(pos);
          ctl.upto = 8'(occupancy);
        end
        default: ;
      endcase
    end else if ((state == S_SCAN) && (op == OP_REMOVE) && !scan_end
                 && (scan_word != val)) begin
      ctl.cmd = CMD_LOAD;
      ctl.from = 8'(kept);
      ctl.upto = 8'(kept);
      load_value = scan_word;
    end
  end

  // walk pointers, occupancy and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
      scan <= '0;
      kept <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        scan <= '0;
        kept <= '0;
        found <= 1'b0;
        found_index <= '0;
      end
      if (state == S_SCAN && !scan_end) begin
        scan <= scan + 1'b1;
        if (op == OP_FIND && scan_word == val) begin
          found <= 1'b1;
          found_index <= POS_W'(scan);
        end
        if (op == OP_REMOVE && scan_word != val) kept <= kept + 1'b1;
      end
      if (state == S_DONE) begin
        out_valid <= 1'b1;
        case (op)
          OP_PUSH_BACK, OP_PUSH_FRONT: begin
            data_out <= '0;
            if (full) status <= ST_FULL;
            else begin
              status <= ST_OK;
              occupancy <= occupancy + 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (occupancy == '0) begin
              status <= ST_BOUNDS;
              data_out <= '0;
            end else begin
              status <= ST_OK;
              data_out <= DATA_W'(cells[IW'(occupancy - 1'b1)]);
              occupancy <= occupancy - 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (occupancy == '0) begin
              status <= ST_BOUNDS;
              data_out <= '0;
            end else begin
              status <= ST_OK;
              data_out <= DATA_W'(cells[0]);
              occupancy <= occupancy - 1'b1;
            end
          end
          OP_REMOVE: begin
            status <= ST_OK;
            data_out <= '0;
            occupancy <= kept;
          end
          OP_INSERT: begin
            data_out <= '0;
            if (!pos_ok) status <= ST_BOUNDS;
            else if (full) status <= ST_FULL;
            else begin
              status <= ST_OK;
              occupancy <= occupancy + 1'b1;
            end
          end
          OP_READ: begin
            if (!pos_ok) begin
              status <= ST_BOUNDS;
              data_out <= '0;
            end else begin
              status <= ST_OK;
              data_out <= DATA_W'(cells[IW'(pos)]);
            end
          end
          default: begin
            status <= ST_OK;
            data_out <= '0;
          end
        endcase
      end
    end
  end

  assign entry_count = CNT_W'(occupancy);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occupancy <= OW'(DEPTH))
    else $error("occupancy beyond depth");
  a_kept_le_scan: assert property (@(posedge clk) disable iff (rst) kept <= scan)
    else $error("compaction write pointer ahead of read pointer");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid)
    else $error("no result after done");
endmodule
